@@ rtl/core/psrm_pkg.sv @@
// Shared types and constants for the positional sequence range-min core.
// Used by psrm_cell, psrm_chain and positional_sequence_range_min_core.
package psrm_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 64;
    localparam int POS_W    = 7;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // common width for position vs. index compares
    localparam int CW       = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic signed [DATA_W-1:0] MIN_IDENTITY = 64'sh1000_0000_0000_0000;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_RMIN   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t        op;
        logic [CW-1:0]   pos;
    } cell_ctl_t;

endpackage

@@ rtl/core/psrm_cell.sv @@
// One storage cell of the sequence chain: holds one value and loads from
// the insert bus, its left or right neighbor. Depends on psrm_pkg.
module psrm_cell (
    input  logic                               clk,
    input  logic [psrm_pkg::CW-1:0]            cell_idx,
    input  psrm_pkg::cell_ctl_t                ctl,
    input  logic signed [psrm_pkg::DATA_W-1:0] ins_value,
    input  logic signed [psrm_pkg::DATA_W-1:0] left_data,
    input  logic signed [psrm_pkg::DATA_W-1:0] right_data,
    output logic signed [psrm_pkg::DATA_W-1:0] data
);
    import psrm_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (cell_idx == ctl.pos)
                    data_next = ins_value;
                else if (cell_idx > ctl.pos)
                    data_next = left_data;
            end
            OP_ERASE:
            begin
                if (cell_idx >= ctl.pos)
                    data_next = right_data;
            end
            OP_ROTATE:
                data_next = right_data;
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ rtl/core/psrm_chain.sv @@
// Row of CAPACITY cells wired as a ring; cell 0 is the head that the
// scan logic watches. Depends on psrm_pkg and psrm_cell.
module psrm_chain (
    input  logic                               clk,
    input  psrm_pkg::cell_ctl_t                ctl,
    input  logic signed [psrm_pkg::DATA_W-1:0] ins_value,
    output logic signed [psrm_pkg::DATA_W-1:0] head
);
    import psrm_pkg::*;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        psrm_cell u_cell (
            .clk        (clk),
            .cell_idx   (CW'(i)),
            .ctl        (ctl),
            .ins_value  (ins_value),
            .left_data  (cell_data[(i + CAPACITY - 1) % CAPACITY]),
            .right_data (cell_data[(i + 1) % CAPACITY]),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

@@ rtl/core/positional_sequence_range_min_core.sv @@
// Top level of the positional sequence range-min core: request FSM,
// output register and the cell chain. Depends on psrm_pkg and psrm_chain.
//
// Keeps an ordered sequence of up to CAPACITY (64) signed 64-bit values in
// a ring of cells. Insert and erase shift the cells in place and take one
// cycle per request; their result beat is offered the cycle after. Read and
// range-min rotate the ring once around, one cell per cycle past the head,
// so they take CAPACITY + 1 cycles before the result beat appears; the ring
// ends where it started. A new request is taken once the result of the
// previous one is taken or being taken. Range-min answers 2^60 for an empty
// range, and stored values above 2^60 count as 2^60.
module positional_sequence_range_min_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // position[6:0], range_end[13:7], value[77:14], zero pad
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata   // result_value[63:0], status[65:64],
                                  // element_count[72:66], zero pad
);
    import psrm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [IDX_W-1:0]        scan_reg;
    logic [CW-1:0]           pos_reg;
    logic [CW-1:0]           end_reg;
    logic                    is_read_reg;
    logic signed [DATA_W-1:0] acc_reg;
    logic                    out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    status_t                 out_status_reg;
    logic [POS_W-1:0]        out_count_reg;

    mode_t                   in_mode;
    logic [CW-1:0]           in_pos;
    logic [CW-1:0]           in_end;
    logic signed [DATA_W-1:0] in_value;
    logic [CW-1:0]           cnt_w;
    logic                    full;
    logic                    accept;
    logic                    out_free;
    cell_ctl_t               ctl;
    logic signed [DATA_W-1:0] head;
    logic [CW-1:0]           scan_w;
    logic                    last_scan;
    logic                    hit;

    assign in_mode  = mode_t'(s_tuser);
    assign in_pos   = CW'(s_tdata[6:0]);
    assign in_end   = CW'(s_tdata[13:7]);
    assign in_value = s_tdata[77:14];
    assign cnt_w    = CW'(count_reg);
    assign full     = count_reg >= CNT_W'(CAPACITY);

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        ctl.op  = OP_HOLD;
        ctl.pos = in_pos;
        if (state_reg == ST_SCAN)
            ctl.op = OP_ROTATE;
        else if (accept)
        begin
            case (in_mode)
                MODE_INSERT:
                begin
                    if (!full)
                    begin
                        ctl.op = OP_INSERT;
                        // past the end appends
                        if (in_pos > cnt_w)
                            ctl.pos = cnt_w;
                    end
                end
                MODE_ERASE:
                begin
                    if (in_pos < cnt_w)
                        ctl.op = OP_ERASE;
                end
                default:
                    ctl.op = OP_HOLD;
            endcase
        end
    end

    psrm_chain u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .ins_value (in_value),
        .head      (head)
    );

    // head holds logical element scan_reg during the scan
    assign scan_w    = CW'(scan_reg);
    assign last_scan = scan_reg == IDX_W'(CAPACITY - 1);
    assign hit = is_read_reg ? (scan_w == pos_reg && pos_reg < cnt_w)
                             : (scan_w >= pos_reg && scan_w < end_reg && head < acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            // a new insert/erase beat reloads the output in the same cycle
            if (out_valid_reg && m_tready &&
                !(accept && (in_mode inside {MODE_INSERT, MODE_ERASE})))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_mode)
                            MODE_INSERT:
                            begin
                                out_valid_reg  <= 1'b1;
                                out_value_reg  <= '0;
                                out_status_reg <= full ? STATUS_FULL : STATUS_OK;
                                out_count_reg  <= full ? POS_W'(count_reg)
                                                       : POS_W'(count_reg + 1'b1);
                                if (!full)
                                    count_reg <= count_reg + 1'b1;
                            end
                            MODE_ERASE:
                            begin
                                out_valid_reg  <= 1'b1;
                                out_value_reg  <= '0;
                                out_status_reg <= STATUS_OK;
                                out_count_reg  <= (in_pos < cnt_w) ? POS_W'(count_reg - 1'b1)
                                                                   : POS_W'(count_reg);
                                if (in_pos < cnt_w)
                                    count_reg <= count_reg - 1'b1;
                            end
                            default:
                            begin
                                state_reg   <= ST_SCAN;
                                scan_reg    <= '0;
                                pos_reg     <= in_pos;
                                end_reg     <= (in_end > cnt_w) ? cnt_w : in_end;
                                is_read_reg <= (in_mode == MODE_READ);
                                acc_reg     <= (in_mode == MODE_READ) ? '0 : MIN_IDENTITY;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (hit)
                        acc_reg <= head;
                    if (last_scan)
                    begin
                        state_reg      <= ST_IDLE;
                        scan_reg       <= '0;
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= hit ? head : acc_reg;
                        out_status_reg <= (is_read_reg && pos_reg >= cnt_w) ? STATUS_RANGE
                                                                           : STATUS_OK;
                        out_count_reg  <= POS_W'(count_reg);
                    end
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_status_reg, out_value_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_no_beat_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && $past(state_reg) == ST_SCAN) |-> !m_tvalid)
        else $error("result beat offered while the ring is still rotating");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_INSERT && !full) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the sequence");

    a_scan_no_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> $stable(count_reg))
        else $error("element count changed during a scan");
`endif

endmodule
